>>> rtl/fca_pkg.sv
// Package for the chain allocator: shared types, codes and register map.
package fca_pkg;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_CHK, ST_CHK2, ST_S1_RD, ST_S1_PR, ST_S2_RD, ST_S2_PR,
        ST_ENDW, ST_H_RD, ST_H_PR, ST_AFIN, ST_FR_RD, ST_FR_PR, ST_FR_FIN,
        ST_EX_RD, ST_EX_PR, ST_DONE
    } t_state;

    localparam logic [1:0] FN_FORMAT = 2'd0;
    localparam logic [1:0] FN_ALLOC  = 2'd1;
    localparam logic [1:0] FN_FREE   = 2'd2;
    localparam logic [1:0] FN_EXTEND = 2'd3;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_NOSPACE = 3'd1;
    localparam logic [2:0] STAT_SIZE    = 3'd2;
    localparam logic [2:0] STAT_BROKEN  = 3'd3;
    localparam logic [2:0] STAT_BAD     = 3'd4;

    localparam logic [2:0] REG_TOTAL    = 3'd0;
    localparam logic [2:0] REG_RESERVED = 3'd1;
    localparam logic [2:0] REG_BBYTES   = 3'd2;
    localparam logic [2:0] REG_MAXBYTES = 3'd3;
    localparam logic [2:0] REG_EXTEND   = 3'd4;

    typedef struct packed {
        logic [12:0] total;
        logic [11:0] reserved;
        logic [15:0] bbytes;
        logic [31:0] maxbytes;
        logic [11:0] extend;
    } t_cfg;

    typedef struct packed {
        logic [31:0] size;
        logic [11:0] index;
        logic [11:0] count;
        logic [1:0]  func;
    } t_req;

    typedef struct packed {
        logic [12:0] first_free;
        logic [12:0] free_count;
        logic [11:0] head_block;
        logic [2:0]  status;
    } t_res;

endpackage

>>> rtl/fca_table.sv
// Chain table memory: one write port, one read port, registered read data.
module fca_table #(
    parameter int TABLE_DEPTH = 4096,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_rdata
);

    logic [AW-1:0] r_mem [TABLE_DEPTH];
    logic [AW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fca_seq.sv
// Sequencer and shared datapath: format sweep, scans, chain walks, checks.
module fca_seq
    import fca_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  t_req          i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_res          o_res,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [AW-1:0] o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [AW-1:0] i_mem_rdata
);

    localparam int HW = (AW + 1 > 13) ? AW + 1 : 13;
    localparam int FW = AW + 1;
    localparam logic [HW-1:0] DEPTH_H = HW'(TABLE_DEPTH);

    t_state        r_state, n_state;
    logic [AW-1:0] r_ptr;
    logic          r_fmt, r_ext_op, r_have;
    logic [11:0]   r_count, r_found, r_left;
    logic [HW-1:0] r_i, r_hint;
    logic [FW-1:0] r_fb, r_cleared, r_steps;
    logic [AW-1:0] r_cur, r_prev, r_start, r_lowest;
    logic [2:0]    r_status;
    logic [27:0]   r_prod;

    logic [HW-1:0] t_lim, res_h, from_h, e_h, idx_h, cnt_h, fb_h, fmt_fb, sum_cl;
    logic          e_zero, e_self, e_use, idx_use, scan_on;

    function automatic logic f_usable(input logic [HW-1:0] x, input logic [HW-1:0] res,
                                      input logic [HW-1:0] lim);
        f_usable = (x > res) && (x < lim);
    endfunction

    always_comb begin
        t_lim   = (HW'(i_cfg.total) > DEPTH_H) ? DEPTH_H : HW'(i_cfg.total);
        res_h   = HW'(i_cfg.reserved);
        from_h  = (r_hint > res_h) ? r_hint : res_h + HW'(1);
        e_h     = HW'(i_mem_rdata);
        idx_h   = HW'(i_req.index);
        cnt_h   = HW'(r_count);
        fb_h    = HW'(r_fb);
        fmt_fb  = (res_h + HW'(1) < t_lim) ? t_lim - res_h - HW'(1) : '0;
        sum_cl  = fb_h + HW'(r_cleared);
        e_zero  = (i_mem_rdata == '0);
        e_self  = (i_mem_rdata == r_cur);
        e_use   = f_usable(e_h, res_h, t_lim);
        idx_use = f_usable(idx_h, res_h, t_lim);
        scan_on = (r_i < t_lim) && (r_found < r_count);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT:  if (r_ptr == AW'(TABLE_DEPTH - 1)) n_state = r_fmt ? ST_DONE : ST_IDLE;
            ST_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.func)
                        FN_FORMAT: n_state = ST_INIT;
                        FN_ALLOC:  n_state = ST_CHK;
                        FN_FREE:   n_state = idx_use ? ST_FR_RD : ST_DONE;
                        default:   n_state = (!idx_use || i_req.size >= i_cfg.maxbytes) ?
                                             ST_DONE : ST_EX_RD;
                    endcase
                end
            end
            ST_CHK:   n_state = (r_count == '0 || fb_h < cnt_h) ? ST_DONE : ST_CHK2;
            ST_CHK2:  n_state = ({4'b0, r_prod} > i_cfg.maxbytes) ? ST_DONE : ST_S1_RD;
            ST_S1_RD: n_state = scan_on ? ST_S1_PR :
                                ((r_found < r_count) ? ST_DONE : ST_S2_RD);
            ST_S1_PR: n_state = ST_S1_RD;
            ST_S2_RD: n_state = ST_S2_PR;
            ST_S2_PR: n_state = (e_zero && r_left == 12'd1) ? ST_ENDW : ST_S2_RD;
            ST_ENDW:  n_state = ST_H_RD;
            ST_H_RD:  n_state = (r_i < t_lim) ? ST_H_PR : ST_AFIN;
            ST_H_PR:  n_state = e_zero ? ST_AFIN : ST_H_RD;
            ST_AFIN:  n_state = ST_DONE;
            ST_FR_RD: n_state = ST_FR_PR;
            ST_FR_PR: n_state = (e_zero || e_self || !e_use ||
                                 r_steps == FW'(TABLE_DEPTH - 1)) ? ST_FR_FIN : ST_FR_RD;
            ST_FR_FIN: n_state = ST_DONE;
            ST_EX_RD: n_state = ST_EX_PR;
            ST_EX_PR: n_state = e_self ? ST_CHK :
                                ((e_zero || !e_use || r_steps == FW'(TABLE_DEPTH)) ?
                                 ST_DONE : ST_EX_RD);
            ST_DONE:  if (i_res_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs and table port
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cur;
        o_mem_wdata = '0;
        o_mem_raddr = r_cur;
        case (r_state)
            ST_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr;
                o_mem_wdata = (HW'(r_ptr) <= res_h) ? AW'(1) : '0;
            end
            ST_S1_RD, ST_S2_RD, ST_H_RD: o_mem_raddr = r_i[AW-1:0];
            ST_S2_PR: begin
                o_mem_we    = e_zero && r_have;
                o_mem_waddr = r_prev;
                o_mem_wdata = r_i[AW-1:0];
            end
            ST_ENDW: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_prev;
                o_mem_wdata = r_prev;
            end
            ST_AFIN: begin
                o_mem_we    = r_ext_op;
                o_mem_wdata = r_start;
            end
            ST_FR_PR: o_mem_we = !e_zero;
            default: ;
        endcase
        o_req_ready            = (r_state == ST_IDLE);
        o_res_valid            = (r_state == ST_DONE);
        o_res.status           = r_status;
        o_res.head_block       = (r_status == STAT_OK) ? 12'(HW'(r_start)) : '0;
        o_res.free_count       = fb_h[12:0];
        o_res.first_free       = r_hint[12:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ptr   <= '0;
            r_fmt   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_INIT: begin
                    r_ptr <= r_ptr + AW'(1);
                    if (r_ptr == AW'(TABLE_DEPTH - 1)) begin
                        r_fb     <= fmt_fb[FW-1:0];
                        r_hint   <= res_h + HW'(1);
                        r_status <= STAT_OK;
                        r_start  <= '0;
                    end
                end
                ST_IDLE: begin
                    r_fmt     <= (i_req.func == FN_FORMAT);
                    r_ext_op  <= (i_req.func == FN_EXTEND);
                    r_count   <= (i_req.func == FN_EXTEND) ? i_cfg.extend : i_req.count;
                    r_cur     <= idx_h[AW-1:0];
                    r_lowest  <= idx_h[AW-1:0];
                    r_start   <= '0;
                    r_steps   <= '0;
                    r_cleared <= '0;
                    r_ptr     <= '0;
                    if (i_req.func == FN_FREE) begin
                        r_status <= idx_use ? STAT_BROKEN : STAT_BAD;
                    end else if (i_req.func == FN_EXTEND && !idx_use) begin
                        r_status <= STAT_BAD;
                    end else if (i_req.func == FN_EXTEND && i_req.size >= i_cfg.maxbytes) begin
                        r_status <= STAT_SIZE;
                    end else begin
                        r_status <= STAT_OK;
                    end
                end
                ST_CHK: begin
                    if (r_count == '0) r_status <= STAT_BAD;
                    else if (fb_h < cnt_h) r_status <= STAT_NOSPACE;
                    r_prod <= 28'(r_count) * 28'(i_cfg.bbytes);
                end
                ST_CHK2: begin
                    if ({4'b0, r_prod} > i_cfg.maxbytes) r_status <= STAT_SIZE;
                    r_i     <= from_h;
                    r_found <= '0;
                end
                ST_S1_RD: begin
                    if (!scan_on) begin
                        if (r_found < r_count) r_status <= STAT_NOSPACE;
                        r_i    <= from_h;
                        r_left <= r_count;
                        r_have <= 1'b0;
                    end
                end
                ST_S1_PR: begin
                    if (e_zero) r_found <= r_found + 12'd1;
                    r_i <= r_i + HW'(1);
                end
                ST_S2_PR: begin
                    if (e_zero) begin
                        if (!r_have) r_start <= r_i[AW-1:0];
                        r_have <= 1'b1;
                        r_prev <= r_i[AW-1:0];
                        r_left <= r_left - 12'd1;
                    end
                    r_i <= r_i + HW'(1);
                end
                ST_ENDW: begin
                    r_fb   <= r_fb - FW'(r_count);
                    r_hint <= t_lim;
                    r_i    <= HW'(r_prev) + HW'(1);
                end
                ST_H_PR: begin
                    if (e_zero) r_hint <= r_i;
                    else r_i <= r_i + HW'(1);
                end
                ST_FR_PR: begin
                    if (!e_zero) begin
                        r_cleared <= r_cleared + FW'(1);
                        if (r_cur < r_lowest) r_lowest <= r_cur;
                        if (e_self) r_status <= STAT_OK;
                        r_cur   <= i_mem_rdata;
                        r_steps <= r_steps + FW'(1);
                    end
                end
                ST_FR_FIN: begin
                    r_fb <= (sum_cl > t_lim) ? t_lim[FW-1:0] : sum_cl[FW-1:0];
                    if (r_cleared != '0 && HW'(r_lowest) < r_hint) r_hint <= HW'(r_lowest);
                end
                ST_EX_PR: begin
                    if (!e_self) begin
                        if (e_zero || !e_use || r_steps == FW'(TABLE_DEPTH))
                            r_status <= STAT_BROKEN;
                        r_cur   <= i_mem_rdata;
                        r_steps <= r_steps + FW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/fat_chain_allocator.sv
// Top level of the chain allocator: register file, result register, table and sequencer.
//
//  channel   dir   handshake                      payload
//  s_axis    in    s_axis_tvalid / s_axis_tready  func, block_count, block_index, size
//  m_axis    out   m_axis_tvalid / m_axis_tready  status, head_block, free_count, first_free
//  apb       in    psel / penable / pready        five config registers at 4*i
//
// One beat at a time. Each table entry read takes an address state and a data state;
// format writes every entry in turn, allocate makes a count pass, a link pass and a hint
// search, free walks the chain, and extend walks the chain and then allocates.
// After reset the table is swept while s_axis_tready stays low; config writes are taken
// throughout. A held result does not block the next beat.
module fat_chain_allocator
    import fca_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // func[1:0], block_count[13:2], block_index[25:14],
                                       // current_size_bytes[57:26], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // status[2:0], head_block[14:3], free_count[27:15],
                                       // first_free[40:28], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(TABLE_DEPTH);

    t_cfg          r_cfg;
    t_req          req;
    t_res          res, r_res;
    logic          r_ovalid, res_valid, res_ready, req_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata;
    logic [2:0]    reg_sel;

    assign reg_sel = paddr[4:2];
    assign pready  = 1'b1;

    // config registers, written on the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total    <= 13'd4096;
            r_cfg.reserved <= 12'd16;
            r_cfg.bbytes   <= 16'd512;
            r_cfg.maxbytes <= 32'd1048576;
            r_cfg.extend   <= 12'd5;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_TOTAL:    r_cfg.total    <= pwdata[12:0];
                REG_RESERVED: r_cfg.reserved <= pwdata[11:0];
                REG_BBYTES:   r_cfg.bbytes   <= pwdata[15:0];
                REG_MAXBYTES: r_cfg.maxbytes <= pwdata;
                REG_EXTEND:   r_cfg.extend   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TOTAL:    prdata = {19'b0, r_cfg.total};
            REG_RESERVED: prdata = {20'b0, r_cfg.reserved};
            REG_BBYTES:   prdata = {16'b0, r_cfg.bbytes};
            REG_MAXBYTES: prdata = r_cfg.maxbytes;
            REG_EXTEND:   prdata = {20'b0, r_cfg.extend};
            default:      prdata = '0;
        endcase
    end

    assign req           = s_axis_tdata[57:0];
    assign s_axis_tready = req_ready;

    // result register: the sequencer hands over when it is empty or draining
    assign res_ready = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'b0, r_res};

    fca_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fca_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule

>>> rtl/fca_checker.sv
// Port checker for the chain allocator, bound to the top level.
module fca_checker
    import fca_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= STAT_BAD)
        else $error("status code out of range");

    a_fail_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != STAT_OK |-> m_axis_tdata[14:3] == 12'd0)
        else $error("failed beat carries a start block");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
